// ===== src/pbps_pkg.sv =====
// Shared types and constants of the polygon boustrophedon path stepper.
package pbps_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int AW           = $clog2(MAX_VERTICES);
    localparam int CW           = $clog2(MAX_VERTICES + 1);
    localparam int MIN_CORNERS  = 3;

    localparam int STEP_W = 12;
    localparam int GAP_W  = 14;
    localparam int CFG_W  = 14;

    localparam logic [STEP_W-1:0] STEP_RESET = 12'd80;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 14'd320;

    localparam logic CFG_STEP = 1'b0;
    localparam logic CFG_GAP  = 1'b1;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_STARTED  = 3'd2;
    localparam logic [2:0] ST_TOO_FEW  = 3'd3;
    localparam logic [2:0] ST_MOVED    = 3'd4;
    localparam logic [2:0] ST_SNAPPED  = 3'd5;
    localparam logic [2:0] ST_TURNED   = 3'd6;
    localparam logic [2:0] ST_IDLE     = 3'd7;

    localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [15:0] COORD_MIN = 16'sh8000;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
    } t_out_item;

endpackage

// ===== src/polygon_boustrophedon_path_stepper.sv =====
// Polygon corner store and zig-zag coverage path stepper.
//
// A command is taken when start is high and busy is low. Operation add stores a
// corner, start places the path on the first row below the top corner, and tick
// advances the path by one move. Every command gives exactly one result, shown
// on o_data for one cycle with o_done high; the receiver cannot hold it off.
// Configuration writes (step size, row gap) go through i_cfg_we/index/data and
// take effect at once; the user makes them only while the block is idle, and
// the block does not enforce this. Add, rejected and idle commands give their
// result in the cycle after acceptance; a plain tick passes through the tick
// state first. Start runs the corner scan and the crossing of the start edge,
// then one row search; a tick turning onto a new row takes two row searches.
// A row search reads every corner; each edge that crosses the row has its
// crossing found by one shared multiplier and a 35-step restoring divider.
// Corners live in a 64-entry RAM with registered read data; each read state is
// followed by a state that uses the word.
// Reset returns the configuration to its defaults and empties the corner list;
// the RAM itself is not cleared, since only stored entries are ever read.
module polygon_boustrophedon_path_stepper
    import pbps_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_in_item        i_data,
    output logic            o_done,
    output t_out_item       o_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [18:0] {
        S_IDLE       = 19'b0000000000000000001,
        S_SCAN_RD    = 19'b0000000000000000010,
        S_SCAN_USE   = 19'b0000000000000000100,
        S_NXT_RD     = 19'b0000000000000001000,
        S_NXT_USE    = 19'b0000000000000010000,
        S_PRV_RD     = 19'b0000000000000100000,
        S_PRV_USE    = 19'b0000000000001000000,
        S_TOPV_RD    = 19'b0000000000010000000,
        S_TOPV_USE   = 19'b0000000000100000000,
        S_MUL        = 19'b0000000001000000000,
        S_DIVINIT    = 19'b0000000010000000000,
        S_DIV        = 19'b0000000100000000000,
        S_DIVEND     = 19'b0000001000000000000,
        S_SC_PRE_RD  = 19'b0000010000000000000,
        S_SC_PRE_USE = 19'b0000100000000000000,
        S_SC_RD      = 19'b0001000000000000000,
        S_SC_USE     = 19'b0010000000000000000,
        S_SC_NEXT    = 19'b0100000000000000000,
        S_TICK       = 19'b1000000000000000000
    } t_state;

    typedef enum logic [1:0] {
        PH_START_CUR,
        PH_START_SCAN,
        PH_TURN1,
        PH_TURN2
    } t_phase;

    localparam int NUM_W = 35;

    function automatic logic signed [15:0] sat16(input logic signed [36:0] v);
        logic signed [15:0] r;
        if (v > 37'sd32767) begin
            r = COORD_MAX;
        end else if (v < -37'sd32768) begin
            r = COORD_MIN;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [36:0] ext37(input logic signed [15:0] v);
        return {{21{v[15]}}, v};
    endfunction

    t_state             r_state;
    t_phase             r_phase;
    logic [CW-1:0]      r_count, r_idx, r_top;
    logic signed [15:0] r_cur_x, r_cur_y, r_dest_x, r_dest_y, r_lowest;
    logic signed [15:0] r_topy, r_bot, r_ax, r_ay, r_bx, r_by, r_nx, r_ny;
    logic signed [15:0] r_best, r_x1;
    logic               r_mv, r_hl, r_run, r_stop, r_left;
    logic [STEP_W-1:0]  r_step;
    logic [GAP_W-1:0]   r_gap;
    logic signed [17:0] r_ey, r_next_row;
    logic signed [34:0] r_prod;
    logic signed [16:0] r_dy;
    logic [NUM_W-1:0]   r_num;
    logic [15:0]        r_den, r_rem;
    logic               r_neg;
    logic [5:0]         r_cnt;
    logic [2:0]         r_status;
    logic               r_done;

    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;
    logic signed [15:0] rd_x, rd_y;

    logic [CW-1:0]      last_idx, nxt_idx, prv_idx;
    logic signed [16:0] mul_dx, dy_c;
    logic signed [17:0] mul_dey, ay18, rdy18, low18;
    logic signed [34:0] mul_p;
    logic [16:0]        rem_sh;
    logic               div_ge;
    logic signed [35:0] div_q;
    logic signed [15:0] edge_x, start_y;
    logic               cross_c, better_c;

    logic signed [16:0] t_ddx, t_ddy;
    logic [15:0]        t_adx, t_ady;
    logic [16:0]        t_dist;
    logic               t_snap, t_stop0, t_vstop;
    logic signed [17:0] t_nrow;

    assign ram_we = start && (r_state == S_IDLE) && (i_data.operation == OP_ADD)
                    && !r_run && (r_count < CW'(MAX_VERTICES));

    pbps_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_corner_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_data.vertex_x, i_data.vertex_y}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[31:16];
    assign rd_y = ram_rdata[15:0];

    assign last_idx = r_count - CW'(1);
    assign nxt_idx  = (r_top == last_idx) ? CW'(0) : r_top + CW'(1);
    assign prv_idx  = (r_top == CW'(0)) ? last_idx : r_top - CW'(1);

    always_comb begin
        unique case (r_state)
            S_SCAN_RD:   ram_raddr = r_idx[AW-1:0];
            S_NXT_RD:    ram_raddr = nxt_idx[AW-1:0];
            S_PRV_RD:    ram_raddr = prv_idx[AW-1:0];
            S_TOPV_RD:   ram_raddr = r_top[AW-1:0];
            S_SC_PRE_RD: ram_raddr = last_idx[AW-1:0];
            S_SC_RD:     ram_raddr = r_idx[AW-1:0];
            default:     ram_raddr = '0;
        endcase
    end

    // Edge crossing: x = ax + trunc((bx-ax)*(y-ay)/(by-ay)).
    assign mul_dx  = {r_bx[15], r_bx} - {r_ax[15], r_ax};
    assign mul_dey = r_ey - {{2{r_ay[15]}}, r_ay};
    assign mul_p   = mul_dx * mul_dey;
    assign dy_c    = {r_by[15], r_by} - {r_ay[15], r_ay};

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign div_ge = rem_sh >= {1'b0, r_den};
    assign div_q  = r_neg ? (36'sd0 - $signed({1'b0, r_num})) : $signed({1'b0, r_num});
    assign edge_x = sat16(ext37(r_ax) + {div_q[35], div_q});
    assign better_c = r_left ? (edge_x < r_best) : (edge_x > r_best);

    assign start_y = sat16(ext37(r_topy) + $signed({23'd0, r_gap}));

    assign ay18    = {{2{r_ay[15]}}, r_ay};
    assign rdy18   = {{2{rd_y[15]}}, rd_y};
    assign low18   = {{2{r_lowest[15]}}, r_lowest};
    assign cross_c = (ay18 < r_ey && rdy18 > r_ey) || (ay18 > r_ey && rdy18 < r_ey);

    assign t_ddx   = {r_dest_x[15], r_dest_x} - {r_cur_x[15], r_cur_x};
    assign t_ddy   = {r_dest_y[15], r_dest_y} - {r_cur_y[15], r_cur_y};
    assign t_adx   = t_ddx[16] ? 16'(-t_ddx) : t_ddx[15:0];
    assign t_ady   = t_ddy[16] ? 16'(-t_ddy) : t_ddy[15:0];
    assign t_dist  = {1'b0, t_adx} + {1'b0, t_ady};
    assign t_snap  = (t_dist != 17'd0) && (t_dist <= {5'd0, r_step});
    assign t_nrow  = {{2{r_cur_y[15]}}, r_cur_y} + $signed({4'd0, r_gap});
    assign t_stop0 = r_cur_y > r_lowest;
    assign t_vstop = t_stop0 || (t_nrow > low18);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_START_CUR;
            r_count  <= '0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_dest_x <= '0;
            r_dest_y <= '0;
            r_lowest <= '0;
            r_mv     <= 1'b0;
            r_hl     <= 1'b0;
            r_run    <= 1'b0;
            r_step   <= STEP_RESET;
            r_gap    <= GAP_RESET;
            r_status <= ST_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_GAP:  r_gap  <= i_cfg_data[GAP_W-1:0];
                    default:  ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_data.operation)
                            OP_ADD: begin
                                if (ram_we) begin
                                    r_count  <= r_count + CW'(1);
                                    r_status <= ST_STORED;
                                end else begin
                                    r_status <= ST_REJECTED;
                                end
                                r_done <= 1'b1;
                            end
                            OP_START: begin
                                if (r_count < CW'(MIN_CORNERS)) begin
                                    r_status <= ST_TOO_FEW;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            OP_TICK: begin
                                if (r_run) begin
                                    r_state <= S_TICK;
                                end else begin
                                    r_status <= ST_IDLE;
                                    r_done   <= 1'b1;
                                end
                            end
                            default: begin
                                r_status <= ST_IDLE;
                                r_done   <= 1'b1;
                            end
                        endcase
                    end
                end

                S_SCAN_RD: r_state <= S_SCAN_USE;

                S_SCAN_USE: begin
                    // First of equal minima wins the top corner.
                    if (r_idx == CW'(0)) begin
                        r_top  <= '0;
                        r_topy <= rd_y;
                        r_bot  <= rd_y;
                    end else begin
                        if (rd_y < r_topy) begin
                            r_top  <= r_idx;
                            r_topy <= rd_y;
                        end
                        if (rd_y > r_bot) begin
                            r_bot <= rd_y;
                        end
                    end
                    if (r_idx == last_idx) begin
                        r_state <= S_NXT_RD;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end

                S_NXT_RD: r_state <= S_NXT_USE;

                S_NXT_USE: begin
                    r_nx    <= rd_x;
                    r_ny    <= rd_y;
                    r_state <= S_PRV_RD;
                end

                S_PRV_RD: r_state <= S_PRV_USE;

                S_PRV_USE: begin
                    if (r_nx > rd_x) begin
                        r_bx <= rd_x;
                        r_by <= rd_y;
                    end else begin
                        r_bx <= r_nx;
                        r_by <= r_ny;
                    end
                    r_state <= S_TOPV_RD;
                end

                S_TOPV_RD: r_state <= S_TOPV_USE;

                S_TOPV_USE: begin
                    r_ax    <= rd_x;
                    r_ay    <= rd_y;
                    r_ey    <= {{2{start_y[15]}}, start_y};
                    r_phase <= PH_START_CUR;
                    r_state <= S_MUL;
                end

                S_MUL: begin
                    r_prod <= mul_p;
                    r_dy   <= dy_c;
                    if (dy_c == 17'sd0) begin
                        // A flat edge answers its start x.
                        r_num   <= '0;
                        r_neg   <= 1'b0;
                        r_state <= S_DIVEND;
                    end else begin
                        r_state <= S_DIVINIT;
                    end
                end

                S_DIVINIT: begin
                    r_num   <= r_prod[34] ? NUM_W'(-r_prod) : NUM_W'(r_prod);
                    r_den   <= r_dy[16] ? 16'(-r_dy) : r_dy[15:0];
                    r_neg   <= r_prod[34] ^ r_dy[16];
                    r_rem   <= '0;
                    r_cnt   <= 6'(NUM_W);
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    r_rem <= div_ge ? 16'(rem_sh - {1'b0, r_den}) : rem_sh[15:0];
                    r_num <= {r_num[NUM_W-2:0], div_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= S_DIVEND;
                    end
                end

                S_DIVEND: begin
                    if (r_phase == PH_START_CUR) begin
                        r_cur_x <= edge_x;
                        r_cur_y <= r_ey[15:0];
                        r_phase <= PH_START_SCAN;
                        r_left  <= 1'b0;
                        r_best  <= COORD_MIN;
                        r_state <= S_SC_PRE_RD;
                    end else begin
                        if (better_c) begin
                            r_best <= edge_x;
                        end
                        r_state <= S_SC_NEXT;
                    end
                end

                S_SC_PRE_RD: r_state <= S_SC_PRE_USE;

                S_SC_PRE_USE: begin
                    // The closing edge runs from the last corner to the first.
                    r_ax    <= rd_x;
                    r_ay    <= rd_y;
                    r_idx   <= '0;
                    r_state <= S_SC_RD;
                end

                S_SC_RD: r_state <= S_SC_USE;

                S_SC_USE: begin
                    r_bx    <= rd_x;
                    r_by    <= rd_y;
                    r_state <= cross_c ? S_MUL : S_SC_NEXT;
                end

                S_SC_NEXT: begin
                    r_ax <= r_bx;
                    r_ay <= r_by;
                    if (r_idx != last_idx) begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SC_RD;
                    end else begin
                        case (r_phase)
                            PH_START_SCAN: begin
                                r_dest_x <= r_best;
                                r_dest_y <= r_cur_y;
                                r_lowest <= r_bot;
                                r_mv     <= 1'b0;
                                r_hl     <= 1'b0;
                                r_run    <= 1'b1;
                                r_status <= ST_STARTED;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                            PH_TURN1: begin
                                r_x1    <= r_best;
                                r_ey    <= r_next_row;
                                r_best  <= r_left ? COORD_MAX : COORD_MIN;
                                r_phase <= PH_TURN2;
                                r_state <= S_SC_PRE_RD;
                            end
                            PH_TURN2: begin
                                // The next row wins when it stays further in
                                // and still lies above the bottom.
                                if ((r_next_row < low18)
                                    && (r_left ? (r_x1 < r_best) : (r_x1 > r_best))) begin
                                    r_dest_x <= r_best;
                                end else begin
                                    r_dest_x <= r_x1;
                                end
                                r_dest_y <= r_cur_y;
                                if (r_stop) begin
                                    r_run    <= 1'b0;
                                    r_status <= ST_IDLE;
                                end else begin
                                    r_status <= ST_TURNED;
                                end
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end
                            PH_START_CUR: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_TICK: begin
                    if (t_snap) begin
                        r_cur_x  <= r_dest_x;
                        r_cur_y  <= r_dest_y;
                        r_status <= t_stop0 ? ST_IDLE : ST_SNAPPED;
                        if (t_stop0) begin
                            r_run <= 1'b0;
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (t_dist == 17'd0) begin
                        r_mv <= !r_mv;
                        if (r_mv) begin
                            // Turning back to horizontal needs two row searches.
                            r_hl       <= !r_hl;
                            r_left     <= !r_hl;
                            r_ey       <= {{2{r_cur_y[15]}}, r_cur_y};
                            r_next_row <= t_nrow;
                            r_stop     <= t_stop0;
                            r_best     <= r_hl ? COORD_MIN : COORD_MAX;
                            r_phase    <= PH_TURN1;
                            r_state    <= S_SC_PRE_RD;
                        end else begin
                            r_dest_x <= r_cur_x;
                            r_dest_y <= sat16({{19{t_nrow[17]}}, t_nrow});
                            r_status <= t_vstop ? ST_IDLE : ST_TURNED;
                            if (t_vstop) begin
                                r_run <= 1'b0;
                            end
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (r_mv) begin
                            r_cur_y <= sat16(ext37(r_cur_y) + $signed({25'd0, r_step}));
                        end else if (r_hl) begin
                            r_cur_x <= sat16(ext37(r_cur_x) - $signed({25'd0, r_step}));
                        end else begin
                            r_cur_x <= sat16(ext37(r_cur_x) + $signed({25'd0, r_step}));
                        end
                        r_status <= t_stop0 ? ST_IDLE : ST_MOVED;
                        if (t_stop0) begin
                            r_run <= 1'b0;
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_data.status   = r_status;
    assign o_data.pos_x    = r_cur_x;
    assign o_data.pos_y    = r_cur_y;
    assign o_data.target_x = r_dest_x;
    assign o_data.target_y = r_dest_y;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while the sequencer is still working");

    a_add_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_data.operation == OP_ADD) |=> r_done)
        else $error("add transaction did not finish in one cycle");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("corner count beyond the RAM depth");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below the divisor");

endmodule

// ===== src/pbps_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module pbps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the polygon boustrophedon path stepper.
module tb;
    import pbps_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item res;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in_item         i_data;
    logic             o_done;
    t_out_item        o_data;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    polygon_boustrophedon_path_stepper uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_data      (i_data),
        .o_done      (o_done),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the path stepper.
    int corner_xs[MAX_VERTICES];
    int corner_ys[MAX_VERTICES];
    int corner_n;
    int path_x, path_y, goal_x, goal_y, bottom_y;
    bit going_down, going_left, path_active;
    int step_len, gap_len;

    t_out_item path_results[$];
    t_row      offered[$];
    int        mismatches;
    int        done_count;
    int        sent;
    int        cycles;

    function automatic int clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int crossing_x(int a, int b, longint y);
        longint sx = corner_xs[a];
        longint sy = corner_ys[a];
        longint dy = longint'(corner_ys[b]) - sy;
        if (dy == 0) return clamp16(sx);
        return clamp16(sx + ((longint'(corner_xs[b]) - sx) * (y - sy)) / dy);
    endfunction

    // Outermost crossing of row y; the far opposite extreme when none crosses.
    function automatic int row_bound(longint y, bit want_left);
        int best;
        int j;
        longint sy;
        longint ey;
        int x;
        best = want_left ? 32767 : -32768;
        for (int i = 0; i < corner_n; i++) begin
            j = (i + 1) % corner_n;
            sy = corner_ys[i];
            ey = corner_ys[j];
            if ((sy < y && ey > y) || (sy > y && ey < y)) begin
                x = crossing_x(i, j, y);
                if (want_left && x < best) best = x;
                if (!want_left && x > best) best = x;
            end
        end
        return best;
    endfunction

    function automatic logic [2:0] begin_path();
        int top;
        int nxt;
        int prv;
        int side;
        int lowest;
        int y;
        if (corner_n < MIN_CORNERS) return ST_TOO_FEW;
        top = 0;
        lowest = corner_ys[0];
        for (int i = 0; i < corner_n; i++) begin
            if (corner_ys[i] < corner_ys[top]) top = i;
            if (corner_ys[i] > lowest) lowest = corner_ys[i];
        end
        nxt = (top + 1) % corner_n;
        prv = (top + corner_n - 1) % corner_n;
        side = (corner_xs[nxt] > corner_xs[prv]) ? prv : nxt;
        y = clamp16(longint'(corner_ys[top]) + gap_len);
        bottom_y = lowest;
        path_x = crossing_x(top, side, y);
        path_y = y;
        goal_x = row_bound(y, 1'b0);
        goal_y = y;
        going_down = 1'b0;
        going_left = 1'b0;
        path_active = 1'b1;
        return ST_STARTED;
    endfunction

    function automatic logic [2:0] advance_path();
        bit     stop;
        longint span;
        longint next_row;
        logic [2:0] st;
        int     x;
        int     xn;
        bit     below;
        stop = path_y > bottom_y;
        next_row = longint'(path_y) + gap_len;
        if (!path_active) return ST_IDLE;
        span = longint'(goal_x) - path_x;
        if (span < 0) span = -span;
        if (goal_y >= path_y) span += longint'(goal_y) - path_y;
        else span += longint'(path_y) - goal_y;
        if (span > 0 && span <= step_len) begin
            path_x = goal_x;
            path_y = goal_y;
            st = ST_SNAPPED;
        end else if (span == 0) begin
            going_down = !going_down;
            if (!going_down) begin
                below = next_row < bottom_y;
                going_left = !going_left;
                x = row_bound(path_y, going_left);
                xn = row_bound(next_row, going_left);
                if (going_left && x < xn && below) x = xn;
                if (!going_left && x > xn && below) x = xn;
                goal_x = x;
                goal_y = path_y;
            end else begin
                if (next_row > bottom_y) stop = 1'b1;
                goal_x = path_x;
                goal_y = clamp16(next_row);
            end
            st = ST_TURNED;
        end else begin
            if (going_down) path_y = clamp16(longint'(path_y) + step_len);
            else if (going_left) path_x = clamp16(longint'(path_x) - step_len);
            else path_x = clamp16(longint'(path_x) + step_len);
            st = ST_MOVED;
        end
        if (stop) begin
            path_active = 1'b0;
            st = ST_IDLE;
        end
        return st;
    endfunction

    function automatic t_out_item predict_path(t_in_item it);
        t_out_item r;
        r.status = ST_IDLE;
        if (it.operation == OP_ADD) begin
            if (path_active || corner_n >= MAX_VERTICES) begin
                r.status = ST_REJECTED;
            end else begin
                corner_xs[corner_n] = it.vertex_x;
                corner_ys[corner_n] = it.vertex_y;
                corner_n++;
                r.status = ST_STORED;
            end
        end else if (it.operation == OP_START) begin
            r.status = begin_path();
        end else if (it.operation == OP_TICK) begin
            r.status = advance_path();
        end
        r.pos_x = path_x[15:0];
        r.pos_y = path_y[15:0];
        r.target_x = goal_x[15:0];
        r.target_y = goal_y[15:0];
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result checking and prediction, both on the rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        t_row      row;
        if (i_rst_n) begin
            if (o_done) begin
                got = o_data;
                done_count++;
                if (path_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result status=%0d at cycle %0d",
                                 got.status, cycles);
                end else begin
                    want = path_results.pop_front();
                    if (got.status !== want.status || got.pos_x !== want.pos_x ||
                        got.pos_y !== want.pos_y || got.target_x !== want.target_x ||
                        got.target_y !== want.target_y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Result %0d: expected st=%0d pos=(%0d,%0d) ",
                                      "dest=(%0d,%0d), got st=%0d pos=(%0d,%0d) ",
                                      "dest=(%0d,%0d)"}, done_count,
                                     want.status, want.pos_x, want.pos_y,
                                     want.target_x, want.target_y,
                                     got.status, got.pos_x, got.pos_y,
                                     got.target_x, got.target_y);
                    end
                end
            end
            if (start && !busy) begin
                want = predict_path(i_data);
                row = offered.pop_front();
                path_results.push_back(row.fixed ? row.res : want);
            end
        end
    end

    function automatic t_in_item make_item(logic [1:0] op, int x, int y);
        t_in_item it;
        it.operation = op;
        it.vertex_x = x[15:0];
        it.vertex_y = y[15:0];
        return it;
    endfunction

    function automatic t_out_item blank_result(logic [2:0] st);
        t_out_item r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic issue(input t_in_item it, input bit fixed, input t_out_item res);
        int idle_pct;
        t_row row;
        idle_pct = (sent < 70) ? 8 : (sent < 140) ? 78 : 0;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        row.item = it;
        row.fixed = fixed;
        row.res = res;
        offered.push_back(row);
        start <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send(input t_in_item it);
        issue(it, 1'b0, '0);
    endtask

    task automatic write_reg(input logic idx, input int value);
        start <= 1'b0;
        @(negedge i_clk);
        while (path_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_W-1:0];
        if (idx == CFG_STEP) step_len = value & 12'hFFF;
        else gap_len = value & 14'h3FFF;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_corner();
        send(make_item(OP_ADD, int'($urandom_range(2400)) - 1200,
                       int'($urandom_range(2400)) - 1200));
    endtask

    // Mostly ticks; the rest is noise of every other operation with full-range fields.
    task automatic send_tick_or_noise();
        int pick;
        pick = $urandom_range(99);
        if (pick < 88) send(make_item(OP_TICK, $urandom, $urandom));
        else if (pick < 93) send(make_item(OP_ADD, $urandom, $urandom));
        else if (pick < 97) send(make_item(OP_UNUSED, $urandom, $urandom));
        else send(make_item(OP_START, $urandom, $urandom));
    endtask

    task automatic run_path(input int ticks, input bit to_end);
        int n;
        n = 0;
        send(make_item(OP_START, $urandom, $urandom));
        while ((to_end ? path_active : 1'b1) && n < ticks) begin
            send_tick_or_noise();
            n++;
        end
    endtask

    task automatic finish_path();
        int n;
        n = 0;
        while (path_active && n < 200) begin
            send(make_item(OP_TICK, $urandom, $urandom));
            n++;
        end
    endtask

    t_row directed[$];

    task automatic add_row(input t_in_item it, input bit fixed, input t_out_item res);
        t_row row;
        row.item = it;
        row.fixed = fixed;
        row.res = res;
        directed.push_back(row);
    endtask

    initial begin
        int paths;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_STEP;
        i_cfg_data = '0;
        mismatches = 0;
        done_count = 0;
        sent = 0;
        cycles = 0;
        corner_n = 0;
        path_x = 0; path_y = 0; goal_x = 0; goal_y = 0; bottom_y = 0;
        going_down = 1'b0; going_left = 1'b0; path_active = 1'b0;
        step_len = STEP_RESET;
        gap_len = GAP_RESET;
        paths = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: idle block, too few corners, unused code, a flat top edge.
        add_row(make_item(OP_TICK, 0, 0), 1'b1, blank_result(ST_IDLE));
        add_row(make_item(OP_START, 0, 0), 1'b1, blank_result(ST_TOO_FEW));
        add_row(make_item(OP_UNUSED, 32767, -32768), 1'b1, blank_result(ST_IDLE));
        add_row(make_item(OP_ADD, 0, -480), 1'b1, blank_result(ST_STORED));
        add_row(make_item(OP_ADD, -640, -480), 1'b1, blank_result(ST_STORED));
        add_row(make_item(OP_START, 0, 0), 1'b1, blank_result(ST_TOO_FEW));
        add_row(make_item(OP_ADD, 640, 160), 1'b1, blank_result(ST_STORED));
        add_row(make_item(OP_START, 0, 0), 1'b0, '0);
        add_row(make_item(OP_ADD, -32768, 32767), 1'b0, '0);
        add_row(make_item(OP_ADD, 32767, -32768), 1'b0, '0);
        for (int i = 0; i < 12; i++) add_row(make_item(OP_TICK, 0, 0), 1'b0, '0);
        add_row(make_item(OP_START, -1, -1), 1'b0, '0);
        add_row(make_item(OP_TICK, -1, -1), 1'b0, '0);
        add_row(make_item(OP_UNUSED, 0, 0), 1'b0, '0);
        foreach (directed[i]) issue(directed[i].item, directed[i].fixed, directed[i].res);
        finish_path();

        // Random part, one register setting after another.
        write_reg(CFG_STEP, 800);
        write_reg(CFG_GAP, 600);
        repeat (4) send_corner();
        run_path(25, 1'b1);
        finish_path();
        paths++;

        write_reg(CFG_STEP, 4095);
        write_reg(CFG_GAP, 16383);
        repeat (2) send_corner();
        run_path(20, 1'b1);
        finish_path();
        paths++;

        // Fill the corner store, walk it, then try one corner too many.
        write_reg(CFG_STEP, 2000);
        write_reg(CFG_GAP, 800);
        while (corner_n < MAX_VERTICES) send_corner();
        run_path(30, 1'b1);
        finish_path();
        send(make_item(OP_ADD, $urandom, $urandom));
        paths++;

        write_reg(CFG_STEP, 1);
        write_reg(CFG_GAP, 16);
        run_path(10, 1'b0);
        paths++;

        start <= 1'b0;
        @(negedge i_clk);
        while (path_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Sent %0d transactions over %0d paths, checked %0d results.",
                 sent, paths + 1, done_count);
        $display("Corner store ended with %0d corners; %0d mismatches.",
                 corner_n, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
